/* design/gtr_pkg.sv */
// Shared types, character codes and expansion functions for the glob-to-regex translator.
// No dependencies; every other design file uses this package.
package gtr_pkg;

  localparam int BYTE_W = 8;
  localparam int DEF_MAX_ALT_DEPTH = 255;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int LEN_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_BAR    = 8'h7C;
  localparam logic [BYTE_W-1:0] CH_BSL    = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_LBRK   = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRK   = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_LPAR   = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAR   = 8'h29;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CLOSE = 2'd1,
    ERR_OPEN  = 2'd2,
    ERR_DEPTH = 2'd3
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MANY  = 2'd0,
    REG_ONE_A = 2'd1,
    REG_ONE_B = 2'd2,
    REG_FMODE = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    K_LIT  = 3'd0,
    K_ESC  = 3'd1,
    K_MANY = 3'd2,
    K_ONE  = 3'd3,
    K_END  = 3'd4,
    K_ERR  = 3'd5
  } kind_t;

  typedef struct packed {
    logic              caret;
    kind_t             kind;
    logic              fmode;
    logic [BYTE_W-1:0] data;
    err_t              err;
    logic              done;
  } job_t;

  function automatic logic is_esc(input logic [BYTE_W-1:0] b);
    return (b == CH_DOT) || (b == CH_BAR) || (b == CH_BSL) || (b == CH_LBRK) ||
           (b == CH_RBRK) || (b == CH_LPAR) || (b == CH_RPAR);
  endfunction

  function automatic logic [LEN_W-1:0] body_len(input kind_t k, input logic fm);
    logic [LEN_W-1:0] n;
    unique case (k)
      K_ESC:   n = 3'd2;
      K_MANY:  n = fm ? 3'd5 : 3'd2;
      K_ONE:   n = fm ? 3'd4 : 3'd1;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] body_byte(input kind_t k, input logic fm,
                                                  input logic [BYTE_W-1:0] d,
                                                  input logic [LEN_W-1:0] j);
    logic [BYTE_W-1:0] b;
    b = CH_NUL;
    unique case (k)
      K_LIT: b = d;
      K_ESC: b = (j == 3'd0) ? CH_BSL : d;
      K_MANY: begin
        if (fm) begin
          unique case (j)
            3'd0:    b = CH_LBRK;
            3'd1:    b = CH_CARET;
            3'd2:    b = CH_SLASH;
            3'd3:    b = CH_RBRK;
            default: b = CH_STAR;
          endcase
        end else begin
          b = (j == 3'd0) ? CH_DOT : CH_STAR;
        end
      end
      K_ONE: begin
        if (fm) begin
          unique case (j)
            3'd0:    b = CH_LBRK;
            3'd1:    b = CH_CARET;
            3'd2:    b = CH_SLASH;
            default: b = CH_RBRK;
          endcase
        end else begin
          b = CH_DOT;
        end
      end
      K_END:   b = CH_DOLLAR;
      default: b = CH_NUL;
    endcase
    return b;
  endfunction

endpackage

/* design/gtr_if.sv */
// Channel interfaces: pattern input, regex output and configuration write.
// Depends on gtr_pkg for field widths.
interface gtr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [gtr_pkg::BYTE_W-1:0] pattern_byte;
  modport source (output valid, output cmd, output pattern_byte, input ready);
  modport sink   (input valid, input cmd, input pattern_byte, output ready);
endinterface

interface gtr_out_if;
  logic                       valid;
  logic                       ready;
  logic [gtr_pkg::BYTE_W-1:0] out_byte;
  logic [1:0]                 error;
  logic                       run_last;
  logic                       pattern_done;
  modport source (output valid, output out_byte, output error, output run_last,
                  output pattern_done, input ready);
  modport sink   (input valid, input out_byte, input error, input run_last,
                  input pattern_done, output ready);
endinterface

interface gtr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gtr_pkg::CFG_IDX_W-1:0] index;
  logic [gtr_pkg::BYTE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/gtr_front.sv */
// Front end: config registers, pattern state and classification of each input beat
// into an expansion job. Depends on gtr_pkg and gtr_if.
module gtr_front #(
  parameter int MAX_ALT_DEPTH = gtr_pkg::DEF_MAX_ALT_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  gtr_in_if.sink        in_if,
  gtr_cfg_if.sink       cfg_if,
  output logic          q_push,
  output gtr_pkg::job_t q_job,
  input  logic          q_full
);
  import gtr_pkg::*;

  localparam int DW = $clog2(MAX_ALT_DEPTH + 1);
  localparam logic [DW-1:0] DMAX = DW'(MAX_ALT_DEPTH);

  logic [BYTE_W-1:0] many_r, one_a_r, one_b_r;
  logic              fmode_r;
  logic              at_start_r, at_start_nxt;
  logic              failed_r, failed_nxt;
  logic [DW-1:0]     depth_r, depth_nxt;
  logic              accept;
  logic              mark;
  logic [BYTE_W-1:0] b;

  assign in_if.ready  = !q_full;
  assign cfg_if.ready = 1'b1;
  assign accept = in_if.valid && in_if.ready;
  assign b = in_if.pattern_byte;
  assign mark = (b == many_r) || (b == one_a_r) || (b == one_b_r);

  always_comb begin
    at_start_nxt = at_start_r;
    failed_nxt   = failed_r;
    depth_nxt    = depth_r;
    q_push       = 1'b0;
    q_job.caret  = 1'b0;
    q_job.kind   = K_LIT;
    q_job.fmode  = fmode_r;
    q_job.data   = b;
    q_job.err    = ERR_NONE;
    q_job.done   = 1'b0;
    if (accept) begin
      if (in_if.cmd) begin
        at_start_nxt = 1'b1;
        failed_nxt   = 1'b0;
        depth_nxt    = '0;
        if (!failed_r) begin
          q_push     = 1'b1;
          q_job.done = 1'b1;
          if (depth_r != '0) begin
            q_job.kind = K_ERR;
            q_job.err  = ERR_OPEN;
          end else begin
            q_job.kind  = K_END;
            q_job.caret = at_start_r;
          end
        end
      end else if (!failed_r) begin
        q_push = 1'b1;
        priority if (b == CH_RBRACE && !mark && depth_r == '0) begin
          q_job.kind = K_ERR;
          q_job.err  = ERR_CLOSE;
          failed_nxt = 1'b1;
        end else if (b == CH_LBRACE && !mark && depth_r >= DMAX) begin
          q_job.kind = K_ERR;
          q_job.err  = ERR_DEPTH;
          failed_nxt = 1'b1;
        end else begin
          q_job.caret  = at_start_r;
          at_start_nxt = 1'b0;
          priority if (b == many_r) begin
            q_job.kind = K_MANY;
          end else if (b == one_a_r || b == one_b_r) begin
            q_job.kind = K_ONE;
          end else if (is_esc(b)) begin
            q_job.kind = K_ESC;
          end else if (b == CH_LBRACE) begin
            q_job.data = CH_LPAR;
            depth_nxt  = depth_r + DW'(1);
          end else if (b == CH_RBRACE) begin
            q_job.data = CH_RPAR;
            depth_nxt  = depth_r - DW'(1);
          end else if (b == CH_COMMA) begin
            q_job.data = (depth_r != '0) ? CH_BAR : CH_COMMA;
          end else begin
            q_job.data = b;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      many_r     <= CH_STAR;
      one_a_r    <= CH_QMARK;
      one_b_r    <= CH_PLUS;
      fmode_r    <= 1'b0;
      at_start_r <= 1'b1;
      failed_r   <= 1'b0;
      depth_r    <= '0;
    end else begin
      at_start_r <= at_start_nxt;
      failed_r   <= failed_nxt;
      depth_r    <= depth_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        unique case (reg_idx_t'(cfg_if.index))
          REG_MANY:  many_r  <= cfg_if.data;
          REG_ONE_A: one_a_r <= cfg_if.data;
          REG_ONE_B: one_b_r <= cfg_if.data;
          REG_FMODE: fmode_r <= cfg_if.data[0];
        endcase
      end
    end
  end

endmodule

/* design/gtr_queue.sv */
// Short job queue between front end and expander.
// Depends on gtr_pkg for the job type and depth.
module gtr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gtr_pkg::job_t push_job,
  input  logic          pop,
  output gtr_pkg::job_t head,
  output logic          full,
  output logic          empty
);
  import gtr_pkg::*;

  job_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   count_r, count_nxt;

  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QAW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
    end
  end

endmodule

/* design/gtr_back.sv */
// Expander: walks the head job one byte per cycle, unless out_if stalls, into the
// output register. Depends on gtr_pkg and gtr_if.
module gtr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  gtr_pkg::job_t head,
  input  logic          q_empty,
  output logic          q_pop,
  gtr_out_if.source     out_if
);
  import gtr_pkg::*;

  logic [LEN_W-1:0]  pos_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] byte_r;
  err_t              err_r;
  logic              last_r, done_r;
  logic              load;
  logic [LEN_W-1:0]  len, j;
  logic              at_last;
  logic [BYTE_W-1:0] cur_byte;

  assign out_if.valid        = out_valid_r;
  assign out_if.out_byte     = byte_r;
  assign out_if.error        = err_r;
  assign out_if.run_last     = last_r;
  assign out_if.pattern_done = done_r;

  assign load    = !q_empty && (!out_valid_r || out_if.ready);
  assign len     = body_len(head.kind, head.fmode) + LEN_W'(head.caret);
  assign at_last = (pos_r == len - LEN_W'(1));
  assign j       = pos_r - LEN_W'(head.caret);
  assign q_pop   = load && at_last;

  always_comb begin
    if (head.caret && pos_r == '0) begin
      cur_byte = CH_CARET;
    end else begin
      cur_byte = body_byte(head.kind, head.fmode, head.data, j);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= cur_byte;
      err_r  <= head.err;
      last_r <= at_last;
      done_r <= at_last && head.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        pos_r       <= at_last ? '0 : pos_r + LEN_W'(1);
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* design/glob_to_regex_translator_core.sv */
// Glob-to-regex translator top level: front end, job queue and expander.
// An accepted input beat is queued as a job, and the expander registers its result beats.
// Throughput: one result beat per cycle while the output is ready; an input beat gives
// 1 to 6 result beats, and input stays open while the 4-entry job queue has room.
// Reset: synchronous, active low; clears pattern state and queue, restores config defaults.
module glob_to_regex_translator_core #(
  parameter int MAX_ALT_DEPTH = gtr_pkg::DEF_MAX_ALT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  gtr_in_if.sink    in_if,
  gtr_cfg_if.sink   cfg_if,
  gtr_out_if.source out_if
);
  import gtr_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  job_t q_job, q_head;

  gtr_front #(
    .MAX_ALT_DEPTH(MAX_ALT_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .q_push (q_push),
    .q_job  (q_job),
    .q_full (q_full)
  );

  gtr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  gtr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full job queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("pop from empty job queue");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.error != ERR_NONE) |-> (out_if.run_last && out_if.out_byte == '0))
    else $error("error beat not a lone zero beat");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.pattern_done) |-> out_if.run_last)
    else $error("pattern_done without run_last");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for glob_to_regex_translator_core: drives glob bytes and register
// writes, predicts every regex beat and compares the beats that come out.
// Depends on gtr_pkg and the channel interfaces in gtr_if.sv.
module testbench;
  import gtr_pkg::*;

  localparam int MAX_DEPTH   = DEF_MAX_ALT_DEPTH;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_PAD   = 10;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] text;
    err_t              err;
    logic              run_last;
    logic              done;
  } regex_beat_t;

  logic clk;
  logic rst_n;

  gtr_in_if  in_bus ();
  gtr_cfg_if cfg_bus ();
  gtr_out_if out_bus ();

  glob_to_regex_translator_core i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .cfg_if(cfg_bus),
    .out_if(out_bus)
  );

  regex_beat_t       pending_regex[$];
  int                mismatches;
  int                beats_sent;
  bit                full_rate;

  logic [BYTE_W-1:0] glob_many;
  logic [BYTE_W-1:0] glob_one_a;
  logic [BYTE_W-1:0] glob_one_b;
  logic              glob_fname;
  logic              caret_due;
  int                brace_depth;
  logic              rejected;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (full_rate || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic is_mark(input logic [BYTE_W-1:0] b);
    return (b == glob_many) || (b == glob_one_a) || (b == glob_one_b);
  endfunction

  function automatic logic needs_escape(input logic [BYTE_W-1:0] b);
    case (b)
      CH_DOT, CH_BAR, CH_BSL, CH_LBRK, CH_RBRK, CH_LPAR, CH_RPAR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic regex_beat_t text_beat(input logic [BYTE_W-1:0] t, input err_t e);
    regex_beat_t r;
    r.text     = t;
    r.err      = e;
    r.run_last = 1'b0;
    r.done     = 1'b0;
    return r;
  endfunction

  function automatic void clear_pattern();
    caret_due   = 1'b1;
    brace_depth = 0;
    rejected    = 1'b0;
  endfunction

  function automatic void translate_glob_beat(input logic cmd, input logic [BYTE_W-1:0] b);
    regex_beat_t run[6];
    int          n;
    string       body;
    n    = 0;
    body = "";
    if (cmd) begin
      if (rejected) begin
        clear_pattern();
        return;
      end
      if (brace_depth > 0) begin
        run[n++] = text_beat(CH_NUL, ERR_OPEN);
      end else begin
        if (caret_due) run[n++] = text_beat(CH_CARET, ERR_NONE);
        run[n++] = text_beat(CH_DOLLAR, ERR_NONE);
      end
      run[n-1].done = 1'b1;
      clear_pattern();
    end else begin
      if (rejected) return;
      if (b == CH_RBRACE && !is_mark(b) && brace_depth == 0) begin
        run[n++] = text_beat(CH_NUL, ERR_CLOSE);
        rejected = 1'b1;
      end else if (b == CH_LBRACE && !is_mark(b) && brace_depth >= MAX_DEPTH) begin
        run[n++] = text_beat(CH_NUL, ERR_DEPTH);
        rejected = 1'b1;
      end else begin
        if (caret_due) begin
          run[n++] = text_beat(CH_CARET, ERR_NONE);
          caret_due = 1'b0;
        end
        if (b == glob_many) begin
          body = glob_fname ? "[^/]*" : ".*";
        end else if (b == glob_one_a || b == glob_one_b) begin
          body = glob_fname ? "[^/]" : ".";
        end else if (needs_escape(b)) begin
          run[n++] = text_beat(CH_BSL, ERR_NONE);
          run[n++] = text_beat(b, ERR_NONE);
        end else if (b == CH_LBRACE) begin
          run[n++] = text_beat(CH_LPAR, ERR_NONE);
          brace_depth++;
        end else if (b == CH_RBRACE) begin
          run[n++] = text_beat(CH_RPAR, ERR_NONE);
          brace_depth--;
        end else if (b == CH_COMMA) begin
          run[n++] = text_beat(brace_depth > 0 ? CH_BAR : CH_COMMA, ERR_NONE);
        end else begin
          run[n++] = text_beat(b, ERR_NONE);
        end
        for (int i = 0; i < body.len(); i++) run[n++] = text_beat(body[i], ERR_NONE);
      end
    end
    run[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) pending_regex.insert(pending_regex.size(), run[i]);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_beat(input logic cmd, input logic [BYTE_W-1:0] b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.cmd          <= cmd;
    in_bus.pattern_byte <= b;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    translate_glob_beat(cmd, b);
    beats_sent++;
  endtask

  task automatic send_glob(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
  endtask

  task automatic settle_idle();
    in_bus.valid <= 1'b0;
    while (pending_regex.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [BYTE_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_MANY:  glob_many  = value;
      REG_ONE_A: glob_one_a = value;
      REG_ONE_B: glob_one_b = value;
      REG_FMODE: glob_fname = value[0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_translation(input logic [BYTE_W-1:0] many, input logic [BYTE_W-1:0] one_a,
                                 input logic [BYTE_W-1:0] one_b, input logic fname);
    logic [6:0] junk;
    junk = 7'($urandom_range(0, 127));
    write_reg(REG_MANY, many);
    write_reg(REG_ONE_A, one_a);
    write_reg(REG_ONE_B, one_b);
    write_reg(REG_FMODE, {junk, fname});
  endtask

  task automatic test_default_map();
    send_beat(1'b1, CH_NUL);
    send_glob("*?+.|\\[]()");
    send_glob(",{a,");
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, CH_RBRACE);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b1, 8'hFF);
    send_glob("}x");
    send_beat(1'b1, CH_NUL);
    send_glob("{");
    send_beat(1'b1, CH_NUL);
    settle_idle();
  endtask

  task automatic test_filename_mode();
    send_glob("a");
    settle_idle();
    set_translation(CH_STAR, CH_QMARK, CH_PLUS, 1'b1);
    send_glob("*?+/");
    send_beat(1'b1, CH_NUL);
    send_glob("{*,?}");
    send_beat(1'b1, CH_NUL);
    settle_idle();
  endtask

  task automatic test_mark_priority();
    set_translation(CH_LBRACE, CH_RBRACE, CH_COMMA, 1'b0);
    send_glob("}{,*?");
    send_beat(1'b1, CH_NUL);
    settle_idle();
    set_translation(8'h00, 8'hFF, 8'h00, 1'b1);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_glob("*?");
    send_beat(1'b1, CH_NUL);
    settle_idle();
  endtask

  task automatic test_depth_overflow();
    set_translation(CH_STAR, CH_QMARK, CH_PLUS, 1'b0);
    repeat (MAX_DEPTH) send_beat(1'b0, CH_LBRACE);
    send_glob("}{{q}");
    send_beat(1'b1, CH_NUL);
    settle_idle();
  endtask

  task automatic send_wellformed_glob();
    int               tokens;
    int               r;
    logic [BYTE_W-1:0] b;
    tokens = $urandom_range(0, 10);
    repeat (tokens) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        b = 8'($urandom_range(0, 255));
        if (!is_mark(b) && ((b == CH_RBRACE && brace_depth == 0) ||
                            (b == CH_LBRACE && brace_depth >= 6))) b = "a";
      end else if (r < 50) begin
        case ($urandom_range(0, 2))
          0:       b = glob_many;
          1:       b = glob_one_a;
          default: b = glob_one_b;
        endcase
      end else if (r < 62) begin
        case ($urandom_range(0, 6))
          0:       b = CH_DOT;
          1:       b = CH_BAR;
          2:       b = CH_BSL;
          3:       b = CH_LBRK;
          4:       b = CH_RBRK;
          5:       b = CH_LPAR;
          default: b = CH_RPAR;
        endcase
      end else if (r < 72) begin
        b = (brace_depth < 6) ? CH_LBRACE : CH_COMMA;
      end else if (r < 82) begin
        b = CH_COMMA;
      end else if (r < 92) begin
        b = (brace_depth > 0) ? CH_RBRACE : CH_COMMA;
      end else begin
        b = 8'($urandom_range(8'h61, 8'h7A));
      end
      send_beat(1'b0, b);
    end
    while (brace_depth > 0 && !rejected && !is_mark(CH_RBRACE)) send_beat(1'b0, CH_RBRACE);
    send_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noisy_glob();
    int               r;
    logic [BYTE_W-1:0] b;
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 3);
      b = (r == 0) ? CH_LBRACE : (r == 1) ? CH_RBRACE : 8'($urandom_range(0, 255));
      send_beat(1'b0, b);
    end
    if ($urandom_range(0, 99) < 85) send_beat(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_globs();
    int target;
    for (int p = 0; p < 8; p++) begin
      settle_idle();
      case (p)
        0:       set_translation(CH_STAR, CH_QMARK, CH_PLUS, 1'b0);
        1:       set_translation(CH_STAR, CH_QMARK, CH_PLUS, 1'b1);
        2:       set_translation(8'h00, 8'hFF, 8'h80, 1'b0);
        3:       set_translation(8'hFF, 8'h00, 8'h00, 1'b1);
        4:       set_translation(CH_LBRACE, CH_RBRACE, CH_COMMA, 1'($urandom_range(0, 1)));
        default: set_translation(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      endcase
      target = beats_sent + 15;
      while (beats_sent < target) begin
        full_rate = ($urandom_range(0, 6) == 0);
        if ($urandom_range(0, 99) < 80) send_wellformed_glob();
        else send_noisy_glob();
      end
    end
    full_rate = 1'b0;
  endtask

  initial begin
    int hold;
    hold          = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        hold = idle_len();
      end
    end
  end

  initial begin
    regex_beat_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (pending_regex.size() == 0) begin
          report("unexpected beat", 32'(out_bus.out_byte), 0);
        end else begin
          want = pending_regex.pop_front();
          if (out_bus.out_byte !== want.text)
            report("out_byte", 32'(out_bus.out_byte), 32'(want.text));
          if (out_bus.error !== want.err)
            report("error", 32'(out_bus.error), 32'(want.err));
          if (out_bus.run_last !== want.run_last)
            report("run_last", 32'(out_bus.run_last), 32'(want.run_last));
          if (out_bus.pattern_done !== want.done)
            report("pattern_done", 32'(out_bus.pattern_done), 32'(want.done));
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
          (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
          (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("testbench failed");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.cmd          = 1'b0;
    in_bus.pattern_byte = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_MANY;
    cfg_bus.data        = '0;
    mismatches          = 0;
    beats_sent          = 0;
    full_rate           = 1'b0;
    glob_many           = CH_STAR;
    glob_one_a          = CH_QMARK;
    glob_one_b          = CH_PLUS;
    glob_fname          = 1'b0;
    clear_pattern();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_map();
    test_filename_mode();
    test_mark_priority();
    test_depth_overflow();
    test_random_globs();
    settle_idle();
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/gtr_pkg.sv
design/gtr_if.sv
design/gtr_front.sv
design/gtr_queue.sv
design/gtr_back.sv
design/glob_to_regex_translator_core.sv
verif/testbench.sv
